/* design/sks_pkg.sv */
// ----------------------------------------------------------------------------
// sks_pkg
// Shared widths, codes and controller/datapath handshake types for the
// sorted key set.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 16;

  localparam int KEY_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int POS_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_ASC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST_DESC = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic list_start;
    logic list_emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_known;
    logic is_list;
    logic empty;
    logic res_free;
    logic list_last;
  } dp_sts_t;

endpackage

/* design/sks_req_if.sv */
// ----------------------------------------------------------------------------
// sks_req_if
// Request channel: command and key with valid/ready.
// ----------------------------------------------------------------------------
interface sks_req_if import sks_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

/* design/sks_res_if.sv */
// ----------------------------------------------------------------------------
// sks_res_if
// Result channel: status, key, listing position and last flag.
// ----------------------------------------------------------------------------
interface sks_res_if import sks_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] found_key;
  logic [POS_W-1:0]        position;
  logic                    last;

  modport source (output valid, status, found_key, position, last, input ready);
  modport sink   (input valid, status, found_key, position, last, output ready);
endinterface

/* design/sks_ctrl.sv */
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: takes a request, runs one execute step, then walks a listing
// one result per cycle while the output register is free.
// ----------------------------------------------------------------------------
module sks_ctrl import sks_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // unknown codes are taken and dropped
        if (in_valid && sts.cmd_known) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_list && !sts.empty) begin
          ctl.list_start = 1'b1;
          state_next     = S_LIST;
        end else if (sts.res_free) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.res_free) begin
          ctl.list_emit = 1'b1;
          if (sts.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec || ctl.list_emit) |-> sts.res_free)
    else $error("result loaded while output register occupied");

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.cmd_known) |=> (state == S_EXEC))
    else $error("captured request not followed by execute step");

  a_list_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.list_start |=> (state == S_LIST))
    else $error("listing start did not enter listing walk");
`endif

endmodule

/* design/sks_datapath.sv */
// ----------------------------------------------------------------------------
// sks_datapath
// Row of compare-and-shift key cells, entry count, listing walker and the
// output register.
// ----------------------------------------------------------------------------
module sks_datapath import sks_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [KEY_W-1:0] in_key,
  input  dp_cmd_t                 ctl,
  output dp_sts_t                 sts,
  sks_res_if.source               rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int REM_W = $clog2(MAX_RESULTS + 1);

  logic signed [KEY_W-1:0] cells      [CAPACITY];
  logic signed [KEY_W-1:0] cells_next [CAPACITY];
  logic [CNT_W-1:0]        count, count_next;

  logic [CMD_W-1:0]        op;
  logic signed [KEY_W-1:0] key_q;

  logic [CAPACITY-1:0]     lt, eq, prev_lt;
  logic                    found, empty, full;

  logic [ST_W-1:0]         res_status;
  logic signed [KEY_W-1:0] res_key;
  logic                    do_ins, do_del;

  logic [IDX_W-1:0]        list_idx;
  logic [REM_W-1:0]        rem;
  logic                    desc;

  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic signed [KEY_W-1:0] out_key;
  logic [POS_W-1:0]        out_pos;
  logic                    out_last;
  logic                    res_free;

  // per-cell compare against the held key, masked to stored entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count) && (cells[i] < key_q);
      eq[i] = (CNT_W'(i) < count) && (cells[i] == key_q);
    end
  end

  assign prev_lt = {lt[CAPACITY-2:0], 1'b1};
  assign found   = |eq;
  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(CAPACITY));

  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    unique case (op) inside
      CMD_INSERT: begin
        if (found) begin
          res_status = ST_DUP;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_key = key_q;
          do_del  = (op == CMD_DELETE);
        end
      end
      // a listing only reaches the execute step on an empty set
      default: res_status = ST_EMPTY;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (ctl.exec && do_ins && !lt[i] && prev_lt[i]) begin
        cells_next[i] = key_q;
      end
    end
    // open a gap above the insertion point
    for (int i = 1; i < CAPACITY; i++) begin
      if (ctl.exec && do_ins && !prev_lt[i]) begin
        cells_next[i] = cells[i-1];
      end
    end
    // close the gap from the matching cell upwards
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (ctl.exec && do_del && !lt[i]) begin
        cells_next[i] = cells[i+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.exec && do_ins) begin
      count_next = count + 1'b1;
    end else if (ctl.exec && do_del) begin
      count_next = count - 1'b1;
    end
  end

  assign res_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctl.exec || ctl.list_emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
    if (ctl.capture) begin
      op    <= in_cmd;
      key_q <= in_key;
    end
    if (ctl.list_start) begin
      desc <= (op == CMD_LIST_DESC);
      list_idx <= (op == CMD_LIST_DESC) ? IDX_W'(count - 1'b1) : '0;
      if (32'(count) < 32'(MAX_RESULTS)) begin
        rem <= REM_W'(count);
      end else begin
        rem <= REM_W'(MAX_RESULTS);
      end
    end else if (ctl.list_emit) begin
      rem      <= rem - 1'b1;
      list_idx <= desc ? list_idx - 1'b1 : list_idx + 1'b1;
    end
    if (ctl.exec) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_pos    <= '0;
      out_last   <= 1'b1;
    end else if (ctl.list_emit) begin
      out_status <= ST_OK;
      out_key    <= cells[list_idx];
      out_pos    <= POS_W'({1'b0, list_idx} + 1'b1);
      out_last   <= (rem == REM_W'(1));
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.found_key = out_key;
  assign rsp.position  = out_pos;
  assign rsp.last      = out_last;

  assign sts.cmd_known = (in_cmd <= CMD_LIST_DESC);
  assign sts.is_list   = (op == CMD_LIST_ASC) || (op == CMD_LIST_DESC);
  assign sts.empty     = empty;
  assign sts.res_free  = res_free;
  assign sts.list_last = (rem == REM_W'(1));

`ifndef ASSERT_OFF
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && do_ins) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the entry count");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && do_del) |=> (count == $past(count) - 1'b1))
    else $error("delete did not shrink the entry count");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.list_emit |-> !empty)
    else $error("listing entry emitted from an empty set");
`endif

endmodule

/* design/sorted_key_set.sv */
// Insert, delete and search: the request is captured, then the compare-and-shift
// execute step registers the result. A listing: capture, a start step that loads
// the walker, then one result per cycle while the output register is free. A new
// request is taken only once idle; output stalls hold the execute step and walk.
// Reset clears the entry count, controller state and output valid; key cells are
// left undefined and are never read before they are written.
// ----------------------------------------------------------------------------
// sorted_key_set
// Bounded ascending set of distinct signed keys with insert, delete, search
// and ascending/descending listing.
// ----------------------------------------------------------------------------
module sorted_key_set import sks_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sks_req_if.sink   req,
  sks_res_if.source rsp
);

  dp_cmd_t ctl;
  dp_sts_t sts;
  logic    in_ready;

  assign req.ready = in_ready;

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  sks_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_cmd (req.cmd),
    .in_key (req.key),
    .ctl    (ctl),
    .sts    (sts),
    .rsp    (rsp)
  );

endmodule

/* tb/tb_sorted_key_set.sv */
// ----------------------------------------------------------------------------
// tb_sorted_key_set
// Self-checking bench for the sorted key set. A behavioural copy of the set
// predicts every result of insert, delete, search and both listings. The
// results are checked field by field as they arrive. Directed cases cover the
// empty set, extreme keys, duplicates and a full store. Random traffic runs
// under several idling and stall patterns. One long output hold-off backs the
// block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_sorted_key_set;
  import sks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] found_key;
    logic [POS_W-1:0]        position;
    logic                    last;
  } set_result_t;

  logic clk;
  logic rst;

  sks_req_if req_if ();
  sks_res_if rsp_if ();

  sorted_key_set #(.CAPACITY(STORE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // predicted contents of the set, ascending
  logic signed [KEY_W-1:0] key_model[$];
  set_result_t             owed_results[$];

  int          mismatch_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_orders;
  int unsigned hold_taken;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void owe(input logic [ST_W-1:0] st, input logic signed [KEY_W-1:0] k,
                              input int pos, input bit fin);
    set_result_t r;
    r.status    = st;
    r.found_key = k;
    r.position  = pos[POS_W-1:0];
    r.last      = fin;
    owed_results.push_back(r);
  endfunction

  // apply one accepted command to the set copy and queue what it must produce
  function automatic void model_command(input logic [CMD_W-1:0] op,
                                        input logic signed [KEY_W-1:0] k);
    int idx;
    int n;
    bit hit;
    idx = 0;
    while (idx < key_model.size() && key_model[idx] < k) idx++;
    hit = (idx < key_model.size()) && (key_model[idx] == k);
    if (op > CMD_LIST_DESC) begin
      return;
    end
    if (op == CMD_INSERT) begin
      if (hit) begin
        owe(ST_DUP, '0, 0, 1'b1);
      end else if (key_model.size() >= STORE_DEPTH) begin
        owe(ST_FULL, '0, 0, 1'b1);
      end else begin
        key_model.insert(idx, k);
        owe(ST_OK, '0, 0, 1'b1);
      end
    end else if (key_model.size() == 0) begin
      owe(ST_EMPTY, '0, 0, 1'b1);
    end else if (op == CMD_DELETE || op == CMD_SEARCH) begin
      if (!hit) begin
        owe(ST_NOTFOUND, '0, 0, 1'b1);
      end else begin
        if (op == CMD_DELETE) key_model.delete(idx);
        owe(ST_OK, k, 0, 1'b1);
      end
    end else begin
      n = (key_model.size() < MAX_RESULTS) ? key_model.size() : MAX_RESULTS;
      for (int i = 0; i < n; i++) begin
        if (op == CMD_LIST_ASC)
          owe(ST_OK, key_model[i], i + 1, i + 1 == n);
        else
          owe(ST_OK, key_model[key_model.size() - 1 - i], key_model.size() - i, i + 1 == n);
      end
    end
  endfunction

  // called at a rising edge; leaves valid high after the transfer
  task automatic send_command(input logic [CMD_W-1:0] op, input logic signed [KEY_W-1:0] k);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= op;
    req_if.key   <= k;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    model_command(op, k);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4 && key_model.size() != 0)
      return key_model[$urandom_range(key_model.size() - 1)];
    if (r < 7)
      return $signed(KEY_W'($urandom_range(23))) - 12;
    if (r == 7) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return CMD_INSERT;
    if (r < 60) return CMD_DELETE;
    if (r < 80) return CMD_SEARCH;
    if (r < 88) return CMD_LIST_ASC;
    if (r < 96) return CMD_LIST_DESC;
    return CMD_W'(CMD_UNUSED_LO + $urandom_range(CMD_UNUSED_HI - CMD_UNUSED_LO));
  endfunction

  // result checking
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d found_key %0d position %0d last %0d",
               rsp_if.status, rsp_if.found_key, rsp_if.position, rsp_if.last);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.found_key !== want.found_key) begin
          $error("found_key: expected %0d, got %0d", want.found_key, rsp_if.found_key);
          mismatch_count++;
        end
        if (rsp_if.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp_if.position);
          mismatch_count++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // output ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_orders != hold_taken) begin
      hold_taken = hold_orders;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sorted_key_set: FAILED **");
      $finish;
    end
  end

  task automatic test_empty_set();
    send_command(CMD_DELETE, 32'sd5);
    send_command(CMD_SEARCH, KEY_MIN);
    send_command(CMD_LIST_ASC, KEY_MAX);
    send_command(CMD_LIST_DESC, '0);
    // unknown commands leave no trace
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
      send_command(CMD_W'(c), $signed($urandom));
  endtask

  task automatic test_directed_keys();
    send_command(CMD_INSERT, KEY_MAX);
    send_command(CMD_INSERT, KEY_MIN);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, KEY_MIN);
    send_command(CMD_SEARCH, KEY_MAX);
    send_command(CMD_SEARCH, 32'sd1);
    send_command(CMD_LIST_ASC, '0);
    send_command(CMD_LIST_DESC, '1);
    send_command(CMD_DELETE, '1);
    send_command(CMD_DELETE, '1);
    send_command(CMD_DELETE, KEY_MIN);
    send_command(CMD_LIST_ASC, '0);
  endtask

  task automatic test_full_store();
    logic signed [KEY_W-1:0] k;
    while (key_model.size() < STORE_DEPTH)
      send_command(CMD_INSERT, $signed($urandom));
    do k = $signed($urandom); while (k inside {key_model});
    send_command(CMD_INSERT, k);
    send_command(CMD_INSERT, key_model[$urandom_range(STORE_DEPTH - 1)]);
    send_command(CMD_LIST_ASC, k);
    send_command(CMD_LIST_DESC, k);
    send_command(CMD_SEARCH, key_model[0]);
    send_command(CMD_SEARCH, key_model[STORE_DEPTH - 1]);
    while (key_model.size() != 0)
      send_command(CMD_DELETE, key_model[$urandom_range(key_model.size() - 1)]);
    send_command(CMD_LIST_DESC, k);
  endtask

  task automatic test_back_pressure();
    hold_orders++;
    for (int i = 0; i < 30; i++) begin
      if (i == 20) send_command(CMD_LIST_ASC, '0);
      else         send_command($urandom_range(1) ? CMD_INSERT : CMD_SEARCH, pick_key());
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int items);
    logic [CMD_W-1:0] op;
    int sent;
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      op = pick_command();
      send_command(op, pick_key());
      if (op <= CMD_LIST_DESC) sent++;
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    sink_stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_orders    = 0;
    hold_taken     = 0;
    hold_left      = 0;
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.cmd     = CMD_INSERT;
    req_if.key     = '0;
    rsp_if.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_set();
    test_directed_keys();
    src_idle_pct   = 36;
    sink_stall_pct = 36;
    test_full_store();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_back_pressure();
    test_random_traffic(0, 0, 65);
    test_random_traffic(51, 0, 65);
    test_random_traffic(0, 51, 65);
    test_random_traffic(36, 36, 65);
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("** sorted_key_set: PASSED **");
    end else begin
      $display("** sorted_key_set: FAILED **");
    end
    $finish;
  end

endmodule
